@@ design/sb2d_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sb2d_pkg
// Shared widths, character codes and types for the signed binary to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sb2d_pkg;

    localparam int ValueW  = 64;
    localparam int DigitW  = 4;
    localparam int NDigits = 19;
    localparam int BcdW    = NDigits * DigitW;
    localparam int CharW   = 8;
    localparam int BitCntW = $clog2(ValueW + 1);
    localparam int DigCntW = $clog2(NDigits + 1);

    localparam logic [CharW-1:0]  DigitBase = 8'd48;
    localparam logic [CharW-1:0]  MinusCode = 8'd45;
    localparam logic [DigitW-1:0] AdjLimit  = 4'd5;
    localparam logic [DigitW-1:0] AdjAdd    = 4'd3;

    typedef struct packed {
        logic start;
        logic negative;
    } emit_cmd_t;

    function automatic logic [DigitW-1:0] digit_adjust(input logic [DigitW-1:0] d);
        logic [DigitW-1:0] r;
        r = (d >= AdjLimit) ? d + AdjAdd : d;
        return r;
    endfunction

endpackage
`default_nettype wire

@@ design/sb2d_dabble.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sb2d_dabble
// Bit-serial double-dabble converter: shifts one magnitude bit per cycle into
// a packed BCD register, adjusting every digit before each shift.
// ----------------------------------------------------------------------------
module sb2d_dabble
    import sb2d_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [ValueW-1:0] magnitude,
    output logic                   done,
    output logic [BcdW-1:0]        bcd
);

    logic [ValueW-1:0]  bin_reg, bin_next;
    logic [BcdW-1:0]    bcd_reg, bcd_next;
    logic [BitCntW-1:0] cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [BcdW-1:0]    bcd_adj;

    always_comb
    begin
        for (int i = 0; i < NDigits; i++)
        begin
            bcd_adj[i*DigitW +: DigitW] = digit_adjust(bcd_reg[i*DigitW +: DigitW]);
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = magnitude;
            bcd_next  = '0;
            cnt_next  = BitCntW'(ValueW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bin_next = {bin_reg[ValueW-2:0], 1'b0};
            bcd_next = {bcd_adj[BcdW-2:0], bin_reg[ValueW-1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == BitCntW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule
`default_nettype wire

@@ design/sb2d_emit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sb2d_emit
// Character emitter: sends an optional minus sign, then shifts the BCD digits
// out most significant first, dropping leading zeros, into an output register.
// ----------------------------------------------------------------------------
module sb2d_emit
    import sb2d_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire emit_cmd_t        cmd,
    input  wire logic [BcdW-1:0]  bcd,
    output logic                  busy,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [CharW-1:0]      m_tdata,  // char_code[7:0]
    output logic                  m_tlast   // last_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SIGN,
        ST_DIGITS
    } state_t;

    state_t             state_reg, state_next;
    logic [BcdW-1:0]    dig_reg, dig_next;
    logic [DigCntW-1:0] left_reg, left_next;
    logic               lead_reg, lead_next;
    logic               valid_reg, valid_next;
    logic [CharW-1:0]   char_reg, char_next;
    logic               last_reg, last_next;
    logic               load;
    logic [DigitW-1:0]  top;
    logic               skip;

    assign load = !valid_reg || m_tready;
    assign top  = dig_reg[BcdW-1 -: DigitW];
    assign skip = lead_reg && (top == '0) && (left_reg > DigCntW'(1));

    always_comb
    begin
        state_next = state_reg;
        dig_next   = dig_reg;
        left_next  = left_reg;
        lead_next  = lead_reg;
        valid_next = valid_reg && !m_tready;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd.start)
                begin
                    dig_next   = bcd;
                    left_next  = DigCntW'(NDigits);
                    lead_next  = 1'b1;
                    state_next = cmd.negative ? ST_SIGN : ST_DIGITS;
                end
            end
            ST_SIGN:
            begin
                if (load)
                begin
                    valid_next = 1'b1;
                    char_next  = MinusCode;
                    last_next  = 1'b0;
                    state_next = ST_DIGITS;
                end
            end
            ST_DIGITS:
            begin
                if (skip)
                begin
                    dig_next  = {dig_reg[BcdW-DigitW-1:0], {DigitW{1'b0}}};
                    left_next = left_reg - 1'b1;
                end
                else if (load)
                begin
                    valid_next = 1'b1;
                    char_next  = DigitBase + {{(CharW-DigitW){1'b0}}, top};
                    last_next  = (left_reg == DigCntW'(1));
                    dig_next   = {dig_reg[BcdW-DigitW-1:0], {DigitW{1'b0}}};
                    left_next  = left_reg - 1'b1;
                    lead_next  = 1'b0;
                    if (left_reg == DigCntW'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            left_reg  <= '0;
            lead_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            left_reg  <= left_next;
            lead_reg  <= lead_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dig_reg  <= dig_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign busy     = (state_reg != ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = char_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

@@ design/signed_binary_to_decimal_ascii.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// signed_binary_to_decimal_ascii
// Prints a signed 64-bit integer as decimal ASCII text, sign first, most
// significant digit first, without leading zeros; tlast marks the last char.
// ----------------------------------------------------------------------------
// Flow: after an input transfer the double-dabble loop shifts in all 64
// magnitude bits, one bit per cycle, then hands the BCD digits to the emitter.
// The emitter drops leading zeros ahead of the first digit and loads one
// character per cycle into the output register while the output is not stalled.
// A new value is accepted only once the previous value's last character is loaded.
// Reset clears all control state; the block then waits for an input transfer.
// ----------------------------------------------------------------------------
module signed_binary_to_decimal_ascii
    import sb2d_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [ValueW-1:0] s_tdata,   // value[63:0]
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [CharW-1:0]       m_tdata,   // char_code[7:0]
    output logic                   m_tlast    // last_char
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic              neg_reg, neg_next;
    logic              accept;
    logic [ValueW-1:0] magnitude;
    logic              conv_done;
    logic [BcdW-1:0]   bcd;
    logic              emit_busy;
    emit_cmd_t         cmd;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign magnitude = s_tdata[ValueW-1] ? (~s_tdata + 1'b1) : s_tdata;

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = s_tdata[ValueW-1];
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                if (conv_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!emit_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            neg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            neg_reg   <= neg_next;
        end
    end

    assign cmd.start    = (state_reg == ST_CONVERT) && conv_done;
    assign cmd.negative = neg_reg;

    sb2d_dabble u_dabble (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (accept),
        .magnitude (magnitude),
        .done      (conv_done),
        .bcd       (bcd)
    );

    sb2d_emit u_emit (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .bcd      (bcd),
        .busy     (emit_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule
`default_nettype wire
